### rtl/fpep_pkg.sv
// shared types, constants and helpers of the fire panel event frame parser
package fpep_pkg;

    // frame size limit and the frame length counter that follows from it
    localparam int MAX_FRAME_LEN = 1024;
    localparam int LEN_W = $clog2(MAX_FRAME_LEN);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_FRAME_LEN - 2);
    localparam logic [LEN_W-1:0] LEN_AFTER_START = LEN_W'(4);
    localparam logic [LEN_W-1:0] LEN_END_MIN = LEN_W'(2);

    // event queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // byte patterns, oldest byte in the top bits
    localparam logic [31:0] MARK_START    = 32'h3138_C4EA;
    localparam logic [31:0] MARK_FIRE     = 32'hBBF0_BEAF;
    localparam logic [31:0] MARK_FEEDBACK = 32'hB7B4_C0A1;
    localparam logic [31:0] MARK_FAULT    = 32'hB9CA_D5CF;
    localparam logic [15:0] MARK_HOST     = 16'hBBFA;
    localparam logic [15:0] MARK_LOOP     = 16'hC2B7;
    localparam logic [15:0] MARK_END      = 16'h0A0A;

    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;
    localparam logic [1:0] POINT_DIGITS = 2'd3;

    typedef enum logic [1:0] {
        KIND_NORMAL = 2'd0,
        KIND_FIRE   = 2'd1,
        KIND_FAULT  = 2'd2
    } kind_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } digit_t;

    // one classified in-frame byte
    typedef struct packed {
        logic       restart;
        digit_t     pt_digit;
        logic       host_hit;
        digit_t     host_digit;
        logic       loop_hit;
        logic [6:0] loop_value;
        logic       loop_bad;
        logic       fire_hit;
        logic       fault_hit;
        logic       end_hit;
    } event_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_stat_t;

    typedef struct packed {
        logic [15:0] source_id;
        logic [3:0]  host_number;
        logic [6:0]  loop_number;
        logic [9:0]  point_number;
        kind_t       event_kind;
        logic        digit_error;
    } result_t;

    // ascii digit decode, a non-digit reads as zero and flags an error
    function automatic digit_t digit_of(input logic [7:0] b);
        digit_t d;
        if (b >= DIGIT_ZERO && b <= DIGIT_NINE)
        begin
            d.bad   = 1'b0;
            d.value = 4'(b - DIGIT_ZERO);
        end
        else
        begin
            d.bad   = 1'b1;
            d.value = 4'd0;
        end
        return d;
    endfunction

endpackage

### rtl/fire_panel_event_frame_parser_top.sv
// top level of the fire panel event frame parser
//
// fire panel event frame parser: takes one serial byte per transfer on the
// input channel, hunts for the start mark 31 38 C4 EA and collects a frame
// until two line feeds close it; every closed frame gives exactly one result
// transfer with the panel id, host digit, loop number, point number, event
// kind and a digit error flag, and bytes outside a frame give none. the block
// takes one byte per clock cycle while the event queue has room. a result
// passes through the event queue and then the back end's result register
// after its closing byte is taken. the front end classifies each byte
// against the four-byte history in the cycle it is taken; a two-entry event
// queue lets the front keep taking bytes while a result waits on the output,
// and in_ready drops only when that queue is full. panel_id is written
// through the configuration channel (always ready) and must only change
// while the block is idle. no clearing pass is needed after reset.
module fire_panel_event_frame_parser_top (
    input  logic        clk,
    input  logic        rst_n,

    // byte input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,

    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] source_id,
    output logic [3:0]  host_number,
    output logic [6:0]  loop_number,
    output logic [9:0]  point_number,
    output logic [1:0]  event_kind,
    output logic        digit_error,

    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] panel_id
);

    logic                  panel_id_reg;
    logic [15:0]           panel_id_q_reg;
    logic                  in_accept;
    logic                  push;
    fpep_pkg::event_t      push_ev;
    fpep_pkg::event_t      pop_ev;
    logic                  pop;
    fpep_pkg::queue_stat_t q_stat;
    fpep_pkg::result_t     result;

    // configuration register, taken on every configuration transfer
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_id_q_reg <= 16'd0;
            panel_id_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            panel_id_q_reg <= panel_id;
            panel_id_reg   <= 1'b1;
        end
    end

    // input transfer while the event queue has room
    assign in_ready  = !q_stat.full;
    assign in_accept = in_valid && in_ready;

    fpep_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .rx_byte (rx_byte),
        .push    (push),
        .push_ev (push_ev)
    );

    fpep_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_ev (push_ev),
        .pop     (pop),
        .pop_ev  (pop_ev),
        .stat    (q_stat)
    );

    fpep_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .panel_id  (panel_id_q_reg),
        .ev_valid  (!q_stat.empty),
        .ev        (pop_ev),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    // unpack the result register onto the output ports
    assign source_id    = result.source_id;
    assign host_number  = result.host_number;
    assign loop_number  = result.loop_number;
    assign point_number = result.point_number;
    assign event_kind   = result.event_kind;
    assign digit_error  = result.digit_error;

`ifndef SYNTHESIS
    // a new result only appears after the back end took a frame-closing event
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(pop && pop_ev.end_hit))
        else $error("result appeared without a frame close");

    // the event queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= fpep_pkg::QCNT_W'(fpep_pkg::QUEUE_DEPTH))
        else $error("event queue overfilled");

    // captured numbers stay within their decimal digit ranges
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (host_number <= 4'd9 && loop_number <= 7'd99 &&
                       point_number <= 10'd999))
        else $error("captured number out of range");

    // a configuration transfer is reflected in the next result source
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (panel_id_reg && panel_id_q_reg == $past(panel_id)))
        else $error("panel id not captured");
`endif

endmodule

### rtl/fpep_front.sv
// front end: byte history, framing and per-byte classification
module fpep_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      rx_byte,
    output logic            push,
    output fpep_pkg::event_t push_ev
);

    logic                       in_frame_reg, in_frame_next;
    logic [fpep_pkg::LEN_W-1:0] len_reg, len_next;
    logic [31:0]                hist_reg, hist_next;

    logic                       clr;
    logic [31:0]                hist_base, hist_new;
    logic [fpep_pkg::LEN_W-1:0] len_new;
    fpep_pkg::digit_t           tens, ones;
    logic                       end_hit;

    always_comb
    begin
        // size limit: start the frame over before taking this byte
        clr       = in_frame_reg && (len_reg >= fpep_pkg::LEN_LIMIT);
        hist_base = clr ? 32'd0 : hist_reg;
        hist_new  = {hist_base[23:0], rx_byte};
        len_new   = (clr ? '0 : len_reg) + 1'b1;
        end_hit   = (len_new > fpep_pkg::LEN_END_MIN) &&
                    (hist_new[15:0] == fpep_pkg::MARK_END);
        tens      = fpep_pkg::digit_of(hist_new[31:24]);
        ones      = fpep_pkg::digit_of(hist_new[23:16]);

        push_ev.restart    = clr;
        push_ev.pt_digit   = fpep_pkg::digit_of(rx_byte);
        push_ev.host_hit   = (hist_new[15:0] == fpep_pkg::MARK_HOST);
        push_ev.host_digit = ones;
        push_ev.loop_hit   = (hist_new[15:0] == fpep_pkg::MARK_LOOP);
        push_ev.loop_value = 7'(7'(tens.value) * 7'd10) + 7'(ones.value);
        push_ev.loop_bad   = tens.bad | ones.bad;
        push_ev.fire_hit   = (hist_new == fpep_pkg::MARK_FIRE) ||
                             (hist_new == fpep_pkg::MARK_FEEDBACK);
        push_ev.fault_hit  = (hist_new == fpep_pkg::MARK_FAULT);
        push_ev.end_hit    = end_hit;

        push          = accept && in_frame_reg;
        in_frame_next = in_frame_reg;
        len_next      = len_reg;
        hist_next     = hist_reg;

        if (accept)
        begin
            if (!in_frame_reg)
            begin
                hist_next = hist_new;
                if (hist_new == fpep_pkg::MARK_START)
                begin
                    in_frame_next = 1'b1;
                    len_next      = fpep_pkg::LEN_AFTER_START;
                end
            end
            else if (end_hit)
            begin
                in_frame_next = 1'b0;
                len_next      = '0;
                hist_next     = 32'd0;
            end
            else
            begin
                hist_next = hist_new;
                len_next  = len_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            len_reg      <= '0;
            hist_reg     <= 32'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            len_reg      <= len_next;
            hist_reg     <= hist_next;
        end
    end

endmodule

### rtl/fpep_queue.sv
// short event queue between front and back
module fpep_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  fpep_pkg::event_t      push_ev,
    input  logic                  pop,
    output fpep_pkg::event_t      pop_ev,
    output fpep_pkg::queue_stat_t stat
);

    fpep_pkg::event_t            q_mem [fpep_pkg::QUEUE_DEPTH];
    logic [fpep_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fpep_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fpep_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        do_push, do_pop;

    localparam logic [fpep_pkg::QPTR_W-1:0] PTR_LAST = fpep_pkg::QPTR_W'(fpep_pkg::QUEUE_DEPTH - 1);
    localparam logic [fpep_pkg::QCNT_W-1:0] CNT_FULL = fpep_pkg::QCNT_W'(fpep_pkg::QUEUE_DEPTH);

    always_comb
    begin
        stat.count = count_reg;
        stat.full  = (count_reg == CNT_FULL);
        stat.empty = (count_reg == '0);
        pop_ev     = q_mem[rd_ptr_reg];
        do_push    = push && !stat.full;
        do_pop     = pop && !stat.empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;

        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= push_ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/fpep_back.sv
// back end: frame captures, keyword flags and the result register
module fpep_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       panel_id,
    input  logic              ev_valid,
    input  fpep_pkg::event_t  ev,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output fpep_pkg::result_t result
);

    logic [3:0]  host_reg, host_next;
    logic [6:0]  loop_reg, loop_next;
    logic [9:0]  point_reg, point_next;
    logic [1:0]  left_reg, left_next;
    logic        fire_reg, fire_next;
    logic        fault_reg, fault_next;
    logic        bad_reg, bad_next;
    logic        out_valid_reg, out_valid_next;
    fpep_pkg::result_t result_reg, result_next;

    logic [3:0]  h;
    logic [6:0]  l;
    logic [9:0]  p;
    logic [1:0]  left;
    logic        fire, fault, bad;
    logic [9:0]  scale;
    logic [19:0] scaled;
    fpep_pkg::result_t res;

    always_comb
    begin
        h     = host_reg;
        l     = loop_reg;
        p     = point_reg;
        left  = left_reg;
        fire  = fire_reg;
        fault = fault_reg;
        bad   = bad_reg;

        if (ev.restart)
        begin
            h     = 4'd0;
            l     = 7'd0;
            p     = 10'd0;
            left  = 2'd0;
            fire  = 1'b0;
            fault = 1'b0;
            bad   = 1'b0;
        end

        // point digits after the loop marker
        if (left != 2'd0)
        begin
            p    = 10'(14'(p) * 14'd10 + 14'(ev.pt_digit.value));
            bad  = bad | ev.pt_digit.bad;
            left = left - 2'd1;
        end

        if (ev.host_hit)
        begin
            h   = ev.host_digit.value;
            bad = bad | ev.host_digit.bad;
        end
        else if (ev.loop_hit)
        begin
            l    = ev.loop_value;
            p    = 10'd0;
            left = fpep_pkg::POINT_DIGITS;
            bad  = bad | ev.loop_bad;
        end

        fire  = fire | ev.fire_hit;
        fault = fault | ev.fault_hit;

        // missing point digits count as zeros
        unique case (left)
            2'd0: scale = 10'd1;
            2'd1: scale = 10'd10;
            2'd2: scale = 10'd100;
            2'd3: scale = 10'd1000;
        endcase
        scaled = 20'(p) * 20'(scale);

        res.source_id    = panel_id;
        res.host_number  = h;
        res.loop_number  = l;
        res.point_number = scaled[9:0];
        res.event_kind   = fire ? fpep_pkg::KIND_FIRE :
                           (fault ? fpep_pkg::KIND_FAULT : fpep_pkg::KIND_NORMAL);
        res.digit_error  = bad | (left != 2'd0);

        // only a frame close waits for the result register to free up
        pop = ev_valid && (!ev.end_hit || !out_valid_reg || out_ready);

        host_next      = host_reg;
        loop_next      = loop_reg;
        point_next     = point_reg;
        left_next      = left_reg;
        fire_next      = fire_reg;
        fault_next     = fault_reg;
        bad_next       = bad_reg;
        result_next    = result_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (pop)
        begin
            if (ev.end_hit)
            begin
                host_next      = 4'd0;
                loop_next      = 7'd0;
                point_next     = 10'd0;
                left_next      = 2'd0;
                fire_next      = 1'b0;
                fault_next     = 1'b0;
                bad_next       = 1'b0;
                result_next    = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                host_next  = h;
                loop_next  = l;
                point_next = p;
                left_next  = left;
                fire_next  = fire;
                fault_next = fault;
                bad_next   = bad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_reg      <= 4'd0;
            loop_reg      <= 7'd0;
            point_reg     <= 10'd0;
            left_reg      <= 2'd0;
            fire_reg      <= 1'b0;
            fault_reg     <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            host_reg      <= host_next;
            loop_reg      <= loop_next;
            point_reg     <= point_next;
            left_reg      <= left_next;
            fire_reg      <= fire_next;
            fault_reg     <= fault_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule
